@@ hw/rtl/voice_slot_manager_with_command_queue_macros.svh @@
// Assertion macros shared by the voice slot manager.
`ifndef VOICE_SLOT_MANAGER_WITH_COMMAND_QUEUE_MACROS_SVH
`define VOICE_SLOT_MANAGER_WITH_COMMAND_QUEUE_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define VSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define VSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vsm_pkg.sv @@
// Package with types and constants of the voice slot manager.
package vsm_pkg;

    localparam int MaxVoices  = 16;
    localparam int QueueDepth = 32;
    localparam int NumBuses   = 4;
    localparam int SlotW      = 4;
    localparam int QPtrW      = 5;
    localparam int QCntW      = 6;
    localparam int CountW     = 5;
    localparam logic [15:0] GainOne = 16'd4096;

    typedef enum logic [2:0] {
        MODE_PLAY   = 3'd0,
        MODE_STOP   = 3'd1,
        MODE_PAUSE  = 3'd2,
        MODE_RESUME = 3'd3,
        MODE_SEEK   = 3'd4,
        MODE_GAIN   = 3'd5,
        MODE_BUSG   = 3'd6,
        MODE_FLUSH  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_SEEK   = 3'd5,
        CMD_GAIN   = 3'd6,
        CMD_BUSG   = 3'd7
    } t_cmd;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StInvalid = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  voice_slot;
        logic [15:0] voice_generation;
        logic [15:0] clip_id;
        logic [15:0] gain;
        logic [15:0] pitch;
        logic [2:0]  bus;
        logic        loop_flag;
        logic [31:0] frame_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_slot;
        logic [15:0] out_generation;
        logic [2:0]  cmd_type;
        logic [15:0] cmd_clip;
        logic [15:0] cmd_gain;
        logic [15:0] cmd_pitch;
        logic [1:0]  cmd_bus;
        logic        cmd_loop;
        logic [31:0] cmd_frame;
        logic [4:0]  active_voices;
        logic        last;
    } t_res;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic        flush;
        logic        disabled;
        t_req        req;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_EXEC  = 2'd1,
        BK_FLUSH = 2'd2
    } t_bk_state;

endpackage

@@ hw/rtl/vsm_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
interface vsm_req_if;
    logic             valid;
    logic             ready;
    vsm_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vsm_res_if;
    logic             valid;
    logic             ready;
    vsm_pkg::t_res    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vsm_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/voice_slot_manager_with_command_queue.sv @@
// Top level of the voice slot manager with command queue.
//  channel | dir | signals
//  req     | in  | req.valid / req.ready / req.data (t_req)
//  res     | out | res.valid / res.ready / res.data (t_res)
//  cfg     | in  | cfg.valid / cfg.ready / cfg.data (enabled)
// A request's result is registered after the job queue and the back part's execute
// state; one request is executed at a time. A flush reads the command ring memory with
// registered reads, one command at a time (a read, then its result once the result
// register is free), at most 32 per flush.
// Reset is synchronous and active low; no clearing pass is needed.
// Either side may stall: the job queue holds two requests, the result register holds one.
`include "voice_slot_manager_with_command_queue_macros.svh"
module voice_slot_manager_with_command_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    vsm_req_if.sink   req,
    vsm_res_if.source res,
    vsm_cfg_if.sink   cfg
);
    logic          r_enabled;
    logic          job_valid, pop;
    vsm_pkg::t_job job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (cfg.valid) begin
            r_enabled <= cfg.data;
        end
    end

    vsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enabled   (r_enabled),
        .req         (req),
        .i_pop       (pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    vsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .res         (res)
    );

    `VSM_ASSERT_IMP(a_pop_needs_job, i_clk, i_rst_n, pop, job_valid,
        "job popped from an empty queue")
    `VSM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, res.valid,
        res.data.active_voices <= 5'd16, "active voice count out of range")
    `VSM_ASSERT_NEXT(a_res_after_pop, i_clk, i_rst_n, pop && !job.flush, res.valid,
        "request executed without a result")
endmodule

@@ hw/rtl/vsm_front.sv @@
// Front part: accepts requests and places them in a short job queue.
module vsm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_enabled,
    vsm_req_if.sink         req,
    input  logic            i_pop,
    output logic            o_job_valid,
    output vsm_pkg::t_job   o_job
);
    // Two entry queue of classified jobs.
    vsm_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    vsm_pkg::t_job job;

    assign req.ready   = (r_cnt != 2'd2);
    assign push        = req.valid && req.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        job.req      = req.data;
        job.flush    = (vsm_pkg::t_mode'(req.data.mode) == vsm_pkg::MODE_FLUSH);
        job.disabled = !i_enabled;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule

@@ hw/rtl/vsm_back.sv @@
// Back part: slot table, command ring and result generation.
module vsm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  vsm_pkg::t_job   i_job,
    output logic            o_pop,
    vsm_res_if.source       res
);
    logic [vsm_pkg::MaxVoices-1:0] r_active, r_paused, r_loop;
    logic [15:0] r_gen  [vsm_pkg::MaxVoices];
    logic [15:0] r_clip [vsm_pkg::MaxVoices];
    logic [15:0] r_sgain[vsm_pkg::MaxVoices];
    logic [1:0]  r_sbus [vsm_pkg::MaxVoices];
    logic [15:0] r_bgain[vsm_pkg::NumBuses];
    logic [vsm_pkg::CountW-1:0] r_act_cnt;

    // Command ring memory: head 23 bits, payload 51 bits.
    logic [22:0] r_qhead[vsm_pkg::QueueDepth];
    logic [50:0] r_qpl  [vsm_pkg::QueueDepth];
    logic [22:0] r_rd_head;
    logic [50:0] r_rd_pl;
    logic [vsm_pkg::QPtrW-1:0] r_rptr, r_wptr;
    logic [vsm_pkg::QCntW-1:0] r_qcnt;

    vsm_pkg::t_bk_state r_state, n_state;
    logic        r_ovalid, n_ovalid;
    vsm_pkg::t_res r_out, n_out;
    logic        r_rd_valid;
    logic [5:0]  r_fl_n;

    vsm_pkg::t_req rq;
    logic        out_free;
    logic        have_free;
    logic [vsm_pkg::SlotW-1:0] free_idx;
    logic        q_full, h_ok, bus_ok;
    logic [15:0] cur_gen, gen_take, gen_bump, gen_retry;
    logic [22:0] w_head;
    logic [50:0] w_pl;
    logic        do_push;
    logic        play_drop;
    logic [1:0]  st;
    logic        fl_emit, fl_take;
    logic [2:0]  fl_type;
    logic        exec_go, flush_start;
    logic [vsm_pkg::CountW-1:0] cnt_after;

    assign rq       = i_job.req;
    assign out_free = !r_ovalid || res.ready;
    assign q_full   = (r_qcnt == vsm_pkg::QCntW'(vsm_pkg::QueueDepth));
    assign bus_ok   = (rq.bus < 3'(vsm_pkg::NumBuses));
    assign cur_gen  = r_gen[rq.voice_slot];
    assign h_ok     = r_active[rq.voice_slot] && (cur_gen == rq.voice_generation);

    always_comb begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int k = vsm_pkg::MaxVoices - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                have_free = 1'b1;
                free_idx  = vsm_pkg::SlotW'(k);
            end
        end
    end

    assign gen_take  = (r_gen[free_idx] == 16'd0) ? 16'd1 : r_gen[free_idx];
    assign gen_bump  = (cur_gen == 16'hFFFF) ? 16'd1 : cur_gen + 16'd1;
    // A play that finds the ring full still takes and releases its slot.
    assign gen_retry = (gen_take == 16'hFFFF) ? 16'd1 : gen_take + 16'd1;

    // Decide the outcome of a non-flush request.
    always_comb begin
        st        = vsm_pkg::StOk;
        do_push   = 1'b0;
        play_drop = 1'b0;
        w_head    = '0;
        w_pl      = '0;
        unique case (vsm_pkg::t_mode'(rq.mode))
            vsm_pkg::MODE_PLAY: begin
                w_head = {vsm_pkg::CMD_PLAY, free_idx, gen_take};
                w_pl   = {rq.loop_flag, rq.bus[1:0], rq.pitch, rq.gain, rq.clip_id};
                if (rq.clip_id == 16'd0 || !bus_ok || rq.pitch == 16'd0) begin
                    st = vsm_pkg::StInvalid;
                end else if (!have_free || q_full) begin
                    st        = vsm_pkg::StFull;
                    play_drop = have_free;
                end else begin
                    do_push = 1'b1;
                end
            end
            vsm_pkg::MODE_BUSG: begin
                w_head = {vsm_pkg::CMD_BUSG, 20'd0};
                w_pl   = {1'b0, rq.bus[1:0], 16'd0, rq.gain, 16'd0};
                if (!bus_ok) begin
                    st = vsm_pkg::StInvalid;
                end else if (q_full) begin
                    st = vsm_pkg::StFull;
                end else begin
                    do_push = 1'b1;
                end
            end
            default: begin
                w_head = {rq.mode + 3'd1, rq.voice_slot, rq.voice_generation};
                if (vsm_pkg::t_mode'(rq.mode) == vsm_pkg::MODE_SEEK) begin
                    w_pl = {19'd0, rq.frame_index};
                end else if (vsm_pkg::t_mode'(rq.mode) == vsm_pkg::MODE_GAIN) begin
                    w_pl = {19'd0, rq.gain, 16'd0};
                end
                if (!h_ok) begin
                    st = vsm_pkg::StInvalid;
                end else if (q_full) begin
                    st = vsm_pkg::StFull;
                end else begin
                    do_push = 1'b1;
                end
            end
        endcase
        if (i_job.disabled) begin
            st        = vsm_pkg::StInvalid;
            do_push   = 1'b0;
            play_drop = 1'b0;
        end
    end

    always_comb begin
        cnt_after = r_act_cnt;
        if (do_push && vsm_pkg::t_mode'(rq.mode) == vsm_pkg::MODE_PLAY) begin
            cnt_after = r_act_cnt + 5'd1;
        end else if (do_push && vsm_pkg::t_mode'(rq.mode) == vsm_pkg::MODE_STOP) begin
            cnt_after = r_act_cnt - 5'd1;
        end
    end

    // Flush: a registered read of the ring head, then its result; one entry at a time.
    assign fl_type = r_rd_head[22:20];
    assign fl_emit = (r_state == vsm_pkg::BK_FLUSH) && r_rd_valid && out_free;
    assign fl_take = (r_state == vsm_pkg::BK_FLUSH) && !r_rd_valid && (r_qcnt != '0)
                     && (r_fl_n != 6'd32);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vsm_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.flush && !i_job.disabled) ? vsm_pkg::BK_FLUSH
                                                                : vsm_pkg::BK_EXEC;
                end
            end
            vsm_pkg::BK_EXEC: begin
                if (out_free) begin
                    n_state = vsm_pkg::BK_IDLE;
                end
            end
            vsm_pkg::BK_FLUSH: begin
                if (out_free && !r_rd_valid && !fl_take) begin
                    n_state = vsm_pkg::BK_IDLE;
                end
            end
            default: n_state = vsm_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        exec_go     = (r_state == vsm_pkg::BK_EXEC) && out_free;
        flush_start = 1'b0;
        o_pop       = 1'b0;
        if (exec_go) begin
            o_pop = 1'b1;
        end
        if (r_state == vsm_pkg::BK_FLUSH && n_state == vsm_pkg::BK_IDLE) begin
            o_pop = 1'b1;
        end
        if (r_state == vsm_pkg::BK_IDLE && n_state == vsm_pkg::BK_FLUSH) begin
            flush_start = 1'b1;
        end
    end

    // Next value of the result register.
    always_comb begin
        n_ovalid = r_ovalid && !res.ready;
        n_out    = r_out;
        if (exec_go) begin
            n_ovalid            = 1'b1;
            n_out               = '0;
            n_out.status        = st;
            n_out.active_voices = cnt_after;
            n_out.last          = 1'b1;
            if (i_job.flush) begin
                n_out.active_voices = r_act_cnt;
            end else if (do_push && vsm_pkg::t_mode'(rq.mode) == vsm_pkg::MODE_PLAY) begin
                n_out.out_slot       = free_idx;
                n_out.out_generation = gen_take;
            end
        end
        if (fl_emit) begin
            n_ovalid            = 1'b1;
            n_out               = '0;
            n_out.cmd_type      = fl_type;
            n_out.active_voices = r_act_cnt;
            n_out.last          = (r_qcnt == '0) || (r_fl_n == 6'd32);
            if (vsm_pkg::t_cmd'(fl_type) != vsm_pkg::CMD_BUSG) begin
                n_out.out_slot       = r_rd_head[19:16];
                n_out.out_generation = r_rd_head[15:0];
            end
            if (vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_PLAY) begin
                n_out.cmd_clip  = r_rd_pl[15:0];
                n_out.cmd_pitch = r_rd_pl[47:32];
                n_out.cmd_loop  = r_rd_pl[50];
            end
            if (vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_PLAY
                || vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_GAIN
                || vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_BUSG) begin
                n_out.cmd_gain = r_rd_pl[31:16];
            end
            if (vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_PLAY
                || vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_BUSG) begin
                n_out.cmd_bus = r_rd_pl[49:48];
            end
            if (vsm_pkg::t_cmd'(fl_type) == vsm_pkg::CMD_SEEK) begin
                n_out.cmd_frame = r_rd_pl[31:0];
            end
        end
        // An empty flush gives a single status-only result.
        if (r_state == vsm_pkg::BK_FLUSH && !r_rd_valid && !fl_take && out_free
            && r_fl_n == 6'd0) begin
            n_ovalid            = 1'b1;
            n_out               = '0;
            n_out.active_voices = r_act_cnt;
            n_out.last          = 1'b1;
        end
    end

    assign res.valid = r_ovalid;
    assign res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (exec_go && do_push) begin
            r_qhead[r_wptr] <= w_head;
            r_qpl[r_wptr]   <= w_pl;
        end
        if (fl_take) begin
            r_rd_head <= r_qhead[r_rptr];
            r_rd_pl   <= r_qpl[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vsm_pkg::BK_IDLE;
            r_ovalid   <= 1'b0;
            r_out      <= '0;
            r_rd_valid <= 1'b0;
            r_fl_n     <= '0;
            r_active   <= '0;
            r_paused   <= '0;
            r_loop     <= '0;
            r_act_cnt  <= '0;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_qcnt     <= '0;
            for (int k = 0; k < vsm_pkg::MaxVoices; k++) begin
                r_gen[k]   <= '0;
                r_clip[k]  <= '0;
                r_sgain[k] <= vsm_pkg::GainOne;
                r_sbus[k]  <= '0;
            end
            for (int k = 0; k < vsm_pkg::NumBuses; k++) begin
                r_bgain[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_out    <= n_out;
            if (flush_start) begin
                r_fl_n <= '0;
            end
            if (exec_go) begin
                if (do_push) begin
                    r_wptr <= (r_wptr == vsm_pkg::QPtrW'(vsm_pkg::QueueDepth - 1)) ? '0
                                                                                     : r_wptr + 1'b1;
                    r_qcnt    <= r_qcnt + 1'b1;
                    r_act_cnt <= cnt_after;
                    unique case (vsm_pkg::t_mode'(rq.mode))
                        vsm_pkg::MODE_PLAY: begin
                            r_gen[free_idx]    <= gen_take;
                            r_clip[free_idx]   <= rq.clip_id;
                            r_sgain[free_idx]  <= rq.gain;
                            r_sbus[free_idx]   <= rq.bus[1:0];
                            r_active[free_idx] <= 1'b1;
                            r_paused[free_idx] <= 1'b0;
                            r_loop[free_idx]   <= rq.loop_flag;
                        end
                        vsm_pkg::MODE_STOP: begin
                            r_gen[rq.voice_slot]    <= gen_bump;
                            r_clip[rq.voice_slot]   <= '0;
                            r_sgain[rq.voice_slot]  <= vsm_pkg::GainOne;
                            r_sbus[rq.voice_slot]   <= '0;
                            r_active[rq.voice_slot] <= 1'b0;
                            r_paused[rq.voice_slot] <= 1'b0;
                            r_loop[rq.voice_slot]   <= 1'b0;
                        end
                        vsm_pkg::MODE_PAUSE:  r_paused[rq.voice_slot] <= 1'b1;
                        vsm_pkg::MODE_RESUME: r_paused[rq.voice_slot] <= 1'b0;
                        vsm_pkg::MODE_GAIN:   r_sgain[rq.voice_slot]  <= rq.gain;
                        vsm_pkg::MODE_BUSG:   r_bgain[rq.bus[1:0]]    <= rq.gain;
                        default: ;
                    endcase
                end else if (play_drop) begin
                    r_gen[free_idx] <= gen_retry;
                end
            end
            if (fl_take) begin
                r_rd_valid <= 1'b1;
                r_rptr <= (r_rptr == vsm_pkg::QPtrW'(vsm_pkg::QueueDepth - 1)) ? '0
                                                                                 : r_rptr + 1'b1;
                r_qcnt <= r_qcnt - 1'b1;
                r_fl_n <= r_fl_n + 6'd1;
            end
            if (fl_emit) begin
                r_rd_valid <= 1'b0;
            end
        end
    end

    // Paused, loop, clip, slot bus and bus gain state is kept for the mixer but not reported.
    logic unused_state;
    assign unused_state = ^{r_paused, r_loop, r_clip[0], r_sbus[0], r_bgain[0]};
endmodule
